FILE: rtl/core/dps_pkg.sv
`default_nettype none

package dps_pkg;

  // Supported transaction lengths
  localparam logic [4:0] WR_LEN_MODE = 5'd1;
  localparam logic [4:0] WR_LEN_BOTH = 5'd2;
  localparam logic [4:0] RD_LEN_MODE = 5'd1;
  localparam logic [4:0] RD_LEN_PRES = 5'd4;
  localparam logic [4:0] RD_LEN_TEMP = 5'd6;
  localparam logic [4:0] RD_LEN_ID = 5'd14;
  localparam logic [4:0] RD_LEN_SER = 5'd18;
  localparam logic [4:0] RD_LEN_ALL = 5'd24;

  // Request type codes
  localparam logic REQ_READ = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Byte positions in a full read
  localparam logic [4:0] IDX_MODE = 5'd0;
  localparam logic [4:0] IDX_PRES_HI = 5'd1;
  localparam logic [4:0] IDX_PRES_MID = 5'd2;
  localparam logic [4:0] IDX_PRES_LO = 5'd3;
  localparam logic [4:0] IDX_TEMP_INT = 5'd4;
  localparam logic [4:0] IDX_TEMP_FRAC = 5'd5;

  // Pressure scaling, all terms divided by 8 from the full-scale formula:
  //   code = floor((p * PCODE_MUL + offset(R)) / den(R))
  //   offset(R) = 16777215 * 49816 * R, den(R) = 99632 * R
  localparam logic [31:0] PCODE_MUL = 32'd3774873375;
  localparam logic [23:0] PCODE_MAX = 24'hFFFFFF;
  localparam int unsigned PCODE_W = 56;
  localparam int unsigned DEN_W = 26;
  localparam int unsigned QUOT_W = 24;

  // Range in tenths of inH2O, selected by mode[2:0]
  function automatic logic [9:0] range_tenths(input logic [2:0] sel);
    logic [9:0] r;
    case (sel)
      3'd0: r = 10'd236;
      3'd1: r = 10'd275;
      3'd2: r = 10'd315;
      3'd3: r = 10'd354;
      3'd4: r = 10'd394;
      3'd5: r = 10'd433;
      3'd6: r = 10'd472;
      3'd7: r = 10'd512;
      default: r = 10'd236;
    endcase
    return r;
  endfunction

  function automatic logic [54:0] range_offset(input logic [2:0] sel);
    logic [63:0] v;
    v = 64'd835773742440 * {54'd0, range_tenths(sel)};
    return v[54:0];
  endfunction

  function automatic logic [DEN_W-1:0] range_den(input logic [2:0] sel);
    logic [31:0] v;
    v = 32'd99632 * {22'd0, range_tenths(sel)};
    return v[DEN_W-1:0];
  endfunction

  // ID string, serial number and build string, bytes 6..23
  function automatic logic [7:0] tail_byte(input logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd6: b = 8'h56;
      5'd7: b = 8'h4E;
      5'd8: b = 8'h31;
      5'd9: b = 8'h33;
      5'd10: b = 8'h31;
      5'd11: b = 8'h43;
      5'd12: b = 8'h4D;
      5'd13: b = 8'h00;
      5'd14: b = 8'hDE;
      5'd15: b = 8'hAD;
      5'd16: b = 8'hBE;
      5'd17: b = 8'hE5;
      5'd18: b = 8'h41;
      5'd19: b = 8'h42;
      5'd20: b = 8'h43;
      5'd21: b = 8'h44;
      5'd22: b = 8'h45;
      5'd23: b = 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dps_if.sv
`default_nettype none

// Request channel
interface dps_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic [4:0] access_len;
  logic [7:0] write_mode;
  logic [7:0] write_rate;
  logic signed [23:0] pressure_in;
  logic signed [15:0] temperature_in;

  modport source (
    output valid, req_type, access_len, write_mode, write_rate, pressure_in, temperature_in,
    input ready
  );
  modport sink (
    input valid, req_type, access_len, write_mode, write_rate, pressure_in, temperature_in,
    output ready
  );
endinterface

// Response channel, one transaction per byte
interface dps_rsp_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic last;
  logic bad_length;

  modport source (
    output valid, data_byte, last, bad_length,
    input ready
  );
  modport sink (
    input valid, data_byte, last, bad_length,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/dps_pcode.sv
`default_nettype none

// Pressure code unit: one multiply, one add, a clamp check, then a restoring
// divider giving one quotient bit per cycle via a shared compare/subtract.
module dps_pcode (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic signed [23:0] pressure,
  input  wire logic [2:0] range_sel,
  output logic done,
  output logic [23:0] code
);

  typedef enum logic [4:0] {
    P_IDLE = 5'b00001,
    P_ADD  = 5'b00010,
    P_CHK  = 5'b00100,
    P_DIV  = 5'b01000,
    P_DONE = 5'b10000
  } pstate_t;

  pstate_t state, state_next;

  logic signed [dps_pkg::PCODE_W-1:0] prod;
  logic signed [dps_pkg::PCODE_W-1:0] num;
  logic [dps_pkg::DEN_W-1:0] den;
  logic [dps_pkg::DEN_W-1:0] rem;
  logic [dps_pkg::QUOT_W-1:0] qsh;
  logic [4:0] cnt;

  // Shared trial subtract
  logic [dps_pkg::DEN_W:0] trial;
  logic [dps_pkg::DEN_W:0] diff;
  logic fits;

  assign trial = {rem, qsh[dps_pkg::QUOT_W-1]};
  assign diff = trial - {1'b0, den};
  assign fits = trial >= {1'b0, den};

  assign done = (state == P_DONE);
  assign code = qsh;

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      P_IDLE: if (start) state_next = P_ADD;
      P_ADD: state_next = P_CHK;
      P_CHK: begin
        if (num[dps_pkg::PCODE_W-1] || ({1'b0, num[54:24]} >= {6'd0, den})) begin
          state_next = P_DONE;
        end else begin
          state_next = P_DIV;
        end
      end
      P_DIV: if (cnt == 5'(dps_pkg::QUOT_W - 1)) state_next = P_DONE;
      P_DONE: state_next = P_IDLE;
      default: state_next = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      P_IDLE: begin
        if (start) begin
          prod <= dps_pkg::PCODE_W'(pressure) *
                  dps_pkg::PCODE_W'($signed({1'b0, dps_pkg::PCODE_MUL}));
          den <= dps_pkg::range_den(range_sel);
          num <= $signed({1'b0, dps_pkg::range_offset(range_sel)});
        end
      end
      P_ADD: num <= prod + num;
      P_CHK: begin
        cnt <= 5'd0;
        if (num[dps_pkg::PCODE_W-1]) begin
          qsh <= '0;
        end else if ({1'b0, num[54:24]} >= {6'd0, den}) begin
          qsh <= dps_pkg::PCODE_MAX;
        end else begin
          rem <= num[49:24];
          qsh <= num[23:0];
        end
      end
      P_DIV: begin
        cnt <= cnt + 5'd1;
        rem <= fits ? diff[dps_pkg::DEN_W-1:0] : trial[dps_pkg::DEN_W-1:0];
        qsh <= {qsh[dps_pkg::QUOT_W-2:0], fits};
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/differential_pressure_sensor_regs.sv
// Read of N supported bytes: the first byte follows the multiply, add, range
// check and 24-step divider, then one byte per cycle while the receiver is
// ready; the divider is skipped when the code saturates.
// An unsupported length gives one error byte.
// Synchronous active-high reset clears mode, rate and the staged values.
`default_nettype none

module differential_pressure_sensor_regs (
  input  wire logic clk,
  input  wire logic rst,
  dps_req_if.sink   req,
  dps_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ERR  = 4'b0010,
    S_CALC = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;

  logic [7:0] mode;
  logic [7:0] rate_control;
  logic [7:0] staged_mode;
  logic [7:0] staged_rate;
  logic staged_pending;

  logic [4:0] len;
  logic [4:0] idx;
  logic signed [15:0] temp;

  logic ovalid;
  logic [7:0] odata;
  logic olast;
  logic obad;

  logic accept;
  logic wr_ok;
  logic rd_ok;
  logic free;
  logic load;
  logic start;
  logic done;
  logic [23:0] code;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign free = !ovalid || rsp.ready;
  assign load = free && ((state == S_ERR) || (state == S_EMIT));

  assign wr_ok = (req.access_len == dps_pkg::WR_LEN_MODE) ||
                 (req.access_len == dps_pkg::WR_LEN_BOTH);
  assign rd_ok = (req.access_len == dps_pkg::RD_LEN_MODE) ||
                 (req.access_len == dps_pkg::RD_LEN_PRES) ||
                 (req.access_len == dps_pkg::RD_LEN_TEMP) ||
                 (req.access_len == dps_pkg::RD_LEN_ID) ||
                 (req.access_len == dps_pkg::RD_LEN_SER) ||
                 (req.access_len == dps_pkg::RD_LEN_ALL);
  assign start = accept && (req.req_type == dps_pkg::REQ_READ) && rd_ok;

  assign rsp.valid = ovalid;
  assign rsp.data_byte = odata;
  assign rsp.last = olast;
  assign rsp.bad_length = obad;

  dps_pcode u_pcode (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .pressure  (req.pressure_in),
    .range_sel (mode[2:0]),
    .done      (done),
    .code      (code)
  );

  // Temperature: integer part toward zero, fraction of the magnitude
  logic [16:0] tmag;
  logic [8:0] tint;
  logic [7:0] tint_byte;

  assign tmag = temp[15] ? (17'd0 - {temp[15], temp}) : {1'b0, temp};
  assign tint = tmag[16:8];
  assign tint_byte = temp[15] ? (8'd0 - tint[7:0]) : tint[7:0];

  // Response byte for the current index
  logic [7:0] cur_byte;
  logic cur_last;

  always_comb begin
    case (idx)
      dps_pkg::IDX_MODE: cur_byte = mode;
      dps_pkg::IDX_PRES_HI: cur_byte = code[23:16];
      dps_pkg::IDX_PRES_MID: cur_byte = code[15:8];
      dps_pkg::IDX_PRES_LO: cur_byte = code[7:0];
      dps_pkg::IDX_TEMP_INT: cur_byte = tint_byte;
      dps_pkg::IDX_TEMP_FRAC: cur_byte = tmag[7:0];
      default: cur_byte = dps_pkg::tail_byte(idx);
    endcase
  end

  assign cur_last = (5'(idx + 5'd1) == len);

  // Output valid: set when a byte is loaded, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (load) begin
      ovalid <= 1'b1;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
  end

  // Transaction sequencer and staging
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= '0;
      rate_control <= '0;
      staged_mode <= '0;
      staged_rate <= '0;
      staged_pending <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.req_type == dps_pkg::REQ_WRITE) begin
              if (wr_ok) begin
                staged_mode <= req.write_mode;
                if (req.access_len == dps_pkg::WR_LEN_BOTH) staged_rate <= req.write_rate;
                staged_pending <= 1'b1;
              end else begin
                state <= S_ERR;
              end
            end else if (rd_ok) begin
              state <= S_CALC;
            end else begin
              state <= S_ERR;
            end
          end
        end
        S_ERR: begin
          if (free) begin
            state <= S_IDLE;
          end
        end
        S_CALC: if (done) state <= S_EMIT;
        S_EMIT: begin
          if (free) begin
            if (cur_last) begin
              state <= S_IDLE;
              if (staged_pending) begin
                mode <= staged_mode;
                rate_control <= staged_rate;
                staged_pending <= 1'b0;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          len <= req.access_len;
          temp <= req.temperature_in;
        end
        idx <= dps_pkg::IDX_MODE;
      end
      S_ERR: begin
        if (free) begin
          odata <= 8'd0;
          olast <= 1'b1;
          obad <= 1'b1;
        end
      end
      S_EMIT: begin
        if (free) begin
          odata <= cur_byte;
          olast <= cur_last;
          obad <= 1'b0;
          idx <= idx + 5'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: dv/tb_differential_pressure_sensor_regs.sv
`timescale 1ns / 1ps

module tb_differential_pressure_sensor_regs;

  // One request as the host issues it
  typedef struct {
    logic               req_type;
    logic [4:0]         access_len;
    logic [7:0]         write_mode;
    logic [7:0]         write_rate;
    logic signed [23:0] pressure;
    logic signed [15:0] temperature;
  } access_t;

  // One response byte transaction
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } reply_byte_t;

  // Pressure code terms: code = (p * PSCALE + OFFSET_PER_R * R) / (DEN_PER_R * R)
  localparam longint PSCALE       = 64'sd30198987000;
  localparam longint OFFSET_PER_R = 64'sd16777215 * 64'sd398528;
  localparam longint DEN_PER_R    = 64'sd797056;
  localparam longint CODE_TOP     = 64'sd16777215;

  // Full-scale range in tenths of inH2O, by mode[2:0]
  localparam int RANGE_TBL [8] = '{236, 275, 315, 354, 394, 433, 472, 512};

  // ID string, serial number and build string, bytes 6..23 of a full read
  localparam logic [7:0] FIXED_TAIL [18] = '{
    8'h56, 8'h4E, 8'h31, 8'h33, 8'h31, 8'h43, 8'h4D, 8'h00,
    8'hDE, 8'hAD, 8'hBE, 8'hE5,
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h00
  };

  logic clk = 1'b0;
  logic rst;

  dps_req_if req ();
  dps_rsp_if rsp ();

  differential_pressure_sensor_regs u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #2 clk = ~clk;

  access_t     access_q[$];
  reply_byte_t reply_bytes_q[$];
  access_t     cur_access;
  int          sent_count;
  int          mismatch_count;
  logic        steady;

  // Shadow copy of the sensor register state
  logic [7:0] sh_mode;
  logic [7:0] sh_rate;
  logic [7:0] sh_staged_mode;
  logic [7:0] sh_staged_rate;
  logic       sh_staged_pending;

  // No idling on either side for a stretch of transactions
  assign steady = (sent_count >= 90) && (sent_count < 150);

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Work out the reply bytes of one accepted access and update the shadow state
  function automatic void compute_reply_bytes(input access_t it);
    logic [7:0] rb [24];
    longint     p;
    longint     r;
    longint     num;
    longint     q;
    int         t;
    int         tmag;
    int         tint;
    int         len;
    bit         ok;
    len = int'(it.access_len);
    if (it.req_type == dps_pkg::REQ_WRITE) begin
      if (it.access_len != dps_pkg::WR_LEN_MODE && it.access_len != dps_pkg::WR_LEN_BOTH) begin
        reply_bytes_q.push_back('{data: 8'h00, last: 1'b1, bad: 1'b1});
        return;
      end
      if (it.access_len == dps_pkg::WR_LEN_BOTH) sh_staged_rate = it.write_rate;
      sh_staged_mode = it.write_mode;
      sh_staged_pending = 1'b1;
      return;
    end
    case (it.access_len)
      dps_pkg::RD_LEN_MODE, dps_pkg::RD_LEN_PRES, dps_pkg::RD_LEN_TEMP,
      dps_pkg::RD_LEN_ID, dps_pkg::RD_LEN_SER, dps_pkg::RD_LEN_ALL: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    if (!ok) begin
      reply_bytes_q.push_back('{data: 8'h00, last: 1'b1, bad: 1'b1});
      return;
    end
    // pressure code, exact then floored and clamped
    p = it.pressure;
    r = RANGE_TBL[sh_mode[2:0]];
    num = p * PSCALE + OFFSET_PER_R * r;
    if (num < 0) q = 0;
    else q = num / (DEN_PER_R * r);
    if (q > CODE_TOP) q = CODE_TOP;
    // temperature: integer part toward zero, fraction of the magnitude
    t = it.temperature;
    tmag = (t < 0) ? -t : t;
    tint = tmag >> 8;
    if (t < 0) tint = -tint;
    rb[dps_pkg::IDX_MODE] = sh_mode;
    rb[dps_pkg::IDX_PRES_HI] = q[23:16];
    rb[dps_pkg::IDX_PRES_MID] = q[15:8];
    rb[dps_pkg::IDX_PRES_LO] = q[7:0];
    rb[dps_pkg::IDX_TEMP_INT] = tint[7:0];
    rb[dps_pkg::IDX_TEMP_FRAC] = tmag[7:0];
    for (int k = 6; k < 24; k++) rb[k] = FIXED_TAIL[k-6];
    for (int k = 0; k < len; k++) begin
      reply_bytes_q.push_back('{data: rb[k], last: (k == len - 1), bad: 1'b0});
    end
    // staged values land once the read is formed
    if (sh_staged_pending) begin
      sh_mode = sh_staged_mode;
      sh_rate = sh_staged_rate;
      sh_staged_pending = 1'b0;
    end
  endfunction

  function automatic access_t mk(input logic typ, input logic [4:0] len, input int wm,
                                 input int wr, input int p, input int t);
    access_t it;
    it.req_type = typ;
    it.access_len = len;
    it.write_mode = 8'(wm);
    it.write_rate = 8'(wr);
    it.pressure = 24'(p);
    it.temperature = 16'(t);
    return it;
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        compute_reply_bytes(cur_access);
        sent_count++;
      end
      if (!req.valid || req.ready) begin
        if (access_q.size() > 0 && (steady || $urandom_range(99) >= 21)) begin
          cur_access = access_q.pop_front();
          req.req_type <= cur_access.req_type;
          req.access_len <= cur_access.access_len;
          req.write_mode <= cur_access.write_mode;
          req.write_rate <= cur_access.write_rate;
          req.pressure_in <= cur_access.pressure;
          req.temperature_in <= cur_access.temperature;
          req.valid <= 1'b1;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and checker
  always @(posedge clk) begin
    reply_byte_t got;
    reply_byte_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{data: rsp.data_byte, last: rsp.last, bad: rsp.bad_length};
        if (reply_bytes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte data=%02h last=%b bad=%b",
                                    got.data, got.last, got.bad));
        end else begin
          want = reply_bytes_q.pop_front();
          if (got !== want)
            report_mismatch($sformatf("data=%02h last=%b bad=%b, want %02h %b %b",
                                      got.data, got.last, got.bad,
                                      want.data, want.last, want.bad));
        end
      end
      rsp.ready <= steady || ($urandom_range(99) >= 21);
    end
  end

  // Stimulus
  initial begin
    access_t it;
    int      sel;
    rst = 1'b1;
    req.valid = 1'b0;
    req.req_type = dps_pkg::REQ_READ;
    req.access_len = '0;
    req.write_mode = '0;
    req.write_rate = '0;
    req.pressure_in = '0;
    req.temperature_in = '0;
    rsp.ready = 1'b0;
    sent_count = 0;
    mismatch_count = 0;
    sh_mode = '0;
    sh_rate = '0;
    sh_staged_mode = '0;
    sh_staged_rate = '0;
    sh_staged_pending = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: every read length, field extremes, saturation both ways
    access_q.push_back(mk(dps_pkg::REQ_READ, dps_pkg::RD_LEN_ALL, 0, 0, 0, 0));
    access_q.push_back(mk(dps_pkg::REQ_READ, dps_pkg::RD_LEN_MODE, 0, 0, 0, 0));
    access_q.push_back(mk(dps_pkg::REQ_READ, dps_pkg::RD_LEN_PRES, 0, 0, 8388607, 0));
    access_q.push_back(mk(dps_pkg::REQ_READ, dps_pkg::RD_LEN_TEMP, 0, 0, -8388608, -32768));
    access_q.push_back(mk(dps_pkg::REQ_READ, dps_pkg::RD_LEN_ID, 0, 0, 52000, 32767));
    access_q.push_back(mk(dps_pkg::REQ_READ, dps_pkg::RD_LEN_SER, 0, 0, -1, -1));
    // two-byte write then one-byte write: rate survives, read sees old mode
    access_q.push_back(mk(dps_pkg::REQ_WRITE, dps_pkg::WR_LEN_BOTH, 'hFF, 'hFF, -1, -1));
    access_q.push_back(mk(dps_pkg::REQ_WRITE, dps_pkg::WR_LEN_MODE, 'h01, 'hAA, 0, 0));
    access_q.push_back(mk(dps_pkg::REQ_READ, dps_pkg::RD_LEN_ALL, 0, 0, 1000, -384));
    // bad lengths: no staging, no apply of a pending stage
    access_q.push_back(mk(dps_pkg::REQ_READ, 5'd0, 0, 0, 0, 0));
    access_q.push_back(mk(dps_pkg::REQ_WRITE, dps_pkg::WR_LEN_BOTH, 'h02, 'h00, 0, 0));
    access_q.push_back(mk(dps_pkg::REQ_READ, 5'd31, 0, 0, 0, 0));
    access_q.push_back(mk(dps_pkg::REQ_READ, dps_pkg::RD_LEN_ALL, 0, 0, -52000, 128));
    access_q.push_back(mk(dps_pkg::REQ_WRITE, 5'd0, 'h07, 'h07, 0, 0));
    access_q.push_back(mk(dps_pkg::REQ_WRITE, 5'd3, 'h07, 'h07, 0, 0));
    access_q.push_back(mk(dps_pkg::REQ_WRITE, 5'd31, 'h07, 'h07, 0, 0));
    access_q.push_back(mk(dps_pkg::REQ_READ, dps_pkg::RD_LEN_TEMP, 0, 0, 30000, 255));
    // walk the remaining ranges
    for (int m = 3; m < 8; m++) begin
      access_q.push_back(mk(dps_pkg::REQ_WRITE, dps_pkg::WR_LEN_MODE, m | (m << 4), 0, 0, 0));
      access_q.push_back(mk(dps_pkg::REQ_READ, dps_pkg::RD_LEN_PRES, 0, 0,
                            (m % 2) ? 40000 : -40000, 0));
    end
    access_q.push_back(mk(dps_pkg::REQ_READ, dps_pkg::RD_LEN_PRES, 0, 0, 60000, 0));

    // hold the sender until the block has drained
    while (access_q.size() != 0 || req.valid || reply_bytes_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    // random: mostly legal reads and writes, some bad lengths
    for (int n = 0; n < 192; n++) begin
      sel = $urandom_range(99);
      it.write_mode = 8'($urandom);
      it.write_rate = 8'($urandom);
      it.temperature = 16'($urandom);
      if ($urandom_range(99) < 65)
        it.pressure = 24'(int'($urandom_range(131071)) - 65536);
      else
        it.pressure = 24'($urandom);
      if (sel < 55) begin
        it.req_type = dps_pkg::REQ_READ;
        case ($urandom_range(5))
          0: it.access_len = dps_pkg::RD_LEN_MODE;
          1: it.access_len = dps_pkg::RD_LEN_PRES;
          2: it.access_len = dps_pkg::RD_LEN_TEMP;
          3: it.access_len = dps_pkg::RD_LEN_ID;
          4: it.access_len = dps_pkg::RD_LEN_SER;
          default: it.access_len = dps_pkg::RD_LEN_ALL;
        endcase
      end else if (sel < 80) begin
        it.req_type = dps_pkg::REQ_WRITE;
        it.access_len = $urandom_range(1) ? dps_pkg::WR_LEN_BOTH : dps_pkg::WR_LEN_MODE;
      end else begin
        it.req_type = (sel < 90) ? dps_pkg::REQ_READ : dps_pkg::REQ_WRITE;
        it.access_len = 5'($urandom);
      end
      access_q.push_back(it);
    end

    // drain, then allow the block's full read latency
    while (access_q.size() != 0 || req.valid || reply_bytes_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (reply_bytes_q.size() != 0)
      report_mismatch($sformatf("%0d reply bytes never arrived", reply_bytes_q.size()));
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
